>>> sv/rgfw_pkg.sv
// ----------------------------------------------------------------------------
// rgfw_pkg
// Shared types and constants for the rotated glyph framebuffer writer.
// ----------------------------------------------------------------------------
package rgfw_pkg;

    localparam int unsigned SCREEN_COLUMNS = 128;
    localparam int unsigned STORE_DEPTH    = 1024;
    localparam int unsigned ADDR_W         = $clog2(STORE_DEPTH);
    localparam int unsigned COL_W          = $clog2(SCREEN_COLUMNS);
    localparam int unsigned PAGE_W         = ADDR_W - COL_W;
    localparam int unsigned PORTRAIT_WIDTH = 64;
    localparam int unsigned PAGE_LIMIT     = 16;
    localparam int unsigned CHAR_ADVANCE   = 4;
    localparam int unsigned GLYPH_ROWS     = 7;
    localparam int unsigned DRAW_COLS      = 3;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic        new_text;
        logic [7:0]  start_x;
        logic [7:0]  text_page;
        logic [7:0]  glyph_col0;
        logic [7:0]  glyph_col1;
        logic [7:0]  glyph_col2;
        logic [7:0]  glyph_col3;
        logic [7:0]  glyph_col4;
        logic [9:0]  read_index;
    } rgfw_in_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        char_drawn;
    } rgfw_out_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_MERGE,
        S_RDONE,
        S_DONE
    } rgfw_state_t;

endpackage

>>> sv/rotated_glyph_framebuffer_writer.sv
// ----------------------------------------------------------------------------
// rotated_glyph_framebuffer_writer
// Page-organised 1024-byte monochrome framebuffer with rotated text drawing.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_ channel (valid/ready), one result beat per
// item leaves on the m_ channel (valid/ready).
// A draw item ORs one squeezed three-column glyph into the framebuffer with
// a read-modify-write per glyph row and byte page: 7 of them, or 14 when the
// three columns straddle two pages. Each is a read in S_FETCH and a write in
// S_MERGE on the single memory port; the result then passes S_DONE to the
// output register. A dropped draw or unused code goes straight to S_DONE, a
// read passes S_FETCH and S_RDONE first. A new item is accepted only in
// S_IDLE, after the last one is through. A clear item sweeps the memory one
// byte per cycle and gives its result after the last byte.
// After reset the same clearing pass over all 1024 bytes runs with s_ready
// low and produces no result beat; cursor and text state reset to zero.
// The result sits in an output register. s_ready returns once an item's
// result enters the output register, even while m_ready is low; a later
// item then waits at its end until the output register is free.
// ----------------------------------------------------------------------------
module rotated_glyph_framebuffer_writer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rgfw_pkg::rgfw_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rgfw_pkg::rgfw_out_t m_data
);
    import rgfw_pkg::*;

    logic [7:0] mem [STORE_DEPTH];

    rgfw_state_t state_reg, state_next;

    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               clr_resp_reg, clr_resp_next;
    logic [6:0]         cursor_reg, cursor_next;
    logic [6:0]         row_base_reg, row_base_next;
    logic               active_reg, active_next;
    logic               m_valid_reg, m_valid_next;

    rgfw_out_t          m_data_reg, m_data_next;
    rgfw_out_t          res_reg, res_next;
    logic [5:0]         draw_x_reg, draw_x_next;
    logic [DRAW_COLS-1:0][GLYPH_ROWS-1:0] col_reg, col_next;
    logic [2:0]         row_reg, row_next;
    logic               page_sel_reg, page_sel_next;
    logic               is_read_reg, is_read_next;
    logic [ADDR_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [7:0]         mem_rdata_reg;

    logic               mem_rd_en, mem_we;
    logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
    logic [7:0]         mem_wdata;

    logic               eff_active;
    logic [6:0]         eff_cursor, eff_row_base;
    logic               draw_ok;
    logic [PAGE_W-1:0]  draw_page;
    logic [ADDR_W-1:0]  draw_addr;
    logic [7:0]         draw_mask;
    logic [5:0]         px;
    logic               straddle;

    // text start / continuation decision for an incoming draw item
    always_comb begin
        eff_active   = active_reg;
        eff_cursor   = cursor_reg;
        eff_row_base = row_base_reg;
        if (s_data.new_text) begin
            if (s_data.start_x < 8'(PORTRAIT_WIDTH) && s_data.text_page < 8'(PAGE_LIMIT)) begin
                eff_active   = 1'b1;
                eff_cursor   = s_data.start_x[6:0];
                eff_row_base = {s_data.text_page[3:0], 3'b000};
            end else begin
                eff_active = 1'b0;
            end
        end
        draw_ok = eff_active && ({1'b0, eff_cursor} + 8'd3 < 8'(PORTRAIT_WIDTH));
    end

    // rotated address: panel column 127 - y, byte page x / 8
    assign draw_page = draw_x_reg[5:3] + PAGE_W'(page_sel_reg);
    assign draw_addr = {draw_page, ~(row_base_reg + {4'b0000, row_reg})};
    assign straddle  = (draw_x_reg[2:0] > 3'd5);

    always_comb begin
        draw_mask = '0;
        px        = '0;
        for (int k = 0; k < DRAW_COLS; k++) begin
            px = draw_x_reg + 6'(k);
            if (px[5:3] == draw_page) begin
                draw_mask[px[2:0]] = draw_mask[px[2:0]] | col_reg[k][row_reg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_resp_next = clr_resp_reg;
        cursor_next   = cursor_reg;
        row_base_next = row_base_reg;
        active_next   = active_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        res_next      = res_reg;
        draw_x_next   = draw_x_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        page_sel_next = page_sel_reg;
        is_read_next  = is_read_reg;
        rd_addr_next  = rd_addr_reg;
        s_ready       = 1'b0;
        mem_rd_en     = 1'b0;
        mem_we        = 1'b0;
        mem_raddr     = draw_addr;
        mem_waddr     = draw_addr;
        mem_wdata     = mem_rdata_reg | draw_mask;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1) begin
                    state_next = clr_resp_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    res_next = '0;
                    unique case (s_data.operation)
                        OP_CLEAR: begin
                            clr_cnt_next  = '0;
                            clr_resp_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        OP_DRAW: begin
                            active_next   = eff_active;
                            cursor_next   = eff_cursor;
                            row_base_next = eff_row_base;
                            if (draw_ok) begin
                                cursor_next   = eff_cursor + 7'(CHAR_ADVANCE);
                                draw_x_next   = eff_cursor[5:0];
                                col_next[0]   = 7'(s_data.glyph_col0 | s_data.glyph_col1);
                                col_next[1]   = 7'(s_data.glyph_col2);
                                col_next[2]   = 7'(s_data.glyph_col3 | s_data.glyph_col4);
                                row_next      = '0;
                                page_sel_next = 1'b0;
                                is_read_next  = 1'b0;
                                state_next    = S_FETCH;
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                        OP_READ: begin
                            rd_addr_next = s_data.read_index;
                            is_read_next = 1'b1;
                            state_next   = S_FETCH;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                mem_rd_en  = 1'b1;
                mem_raddr  = is_read_reg ? rd_addr_reg : draw_addr;
                state_next = is_read_reg ? S_RDONE : S_MERGE;
            end
            S_MERGE: begin
                mem_we = 1'b1;
                if (row_reg == 3'(GLYPH_ROWS - 1)) begin
                    if (straddle && !page_sel_reg) begin
                        page_sel_next = 1'b1;
                        row_next      = '0;
                        state_next    = S_FETCH;
                    end else begin
                        res_next.char_drawn = 1'b1;
                        state_next          = S_DONE;
                    end
                end else begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_RDONE: begin
                res_next.read_data = mem_rdata_reg;
                state_next         = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = res_reg;
                    clr_resp_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_resp_reg <= 1'b0;
            cursor_reg   <= '0;
            row_base_reg <= '0;
            active_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_resp_reg <= clr_resp_next;
            cursor_reg   <= cursor_next;
            row_base_reg <= row_base_next;
            active_reg   <= active_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        res_reg      <= res_next;
        draw_x_reg   <= draw_x_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        page_sel_reg <= page_sel_next;
        is_read_reg  <= is_read_next;
        rd_addr_reg  <= rd_addr_next;
    end

    // single-port style framebuffer, registered read
    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_one_field_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.char_drawn && m_data.read_data != 8'd0))
        else $error("draw and read data both set in one result beat");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready held after accepting an item");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MERGE || (state_reg == S_FETCH && !is_read_reg))
            |-> row_reg < 3'(GLYPH_ROWS))
        else $error("glyph row counter out of range");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_MERGE))
        else $error("framebuffer written outside clear or merge");

endmodule
